// ===== design/pl_pkg.sv =====
// Shared types, token codes and the keyword table for the pseudocode lexer.
// Used by pl_kw_match and pseudocode_lexer; depends on nothing else.
`default_nettype none

package pl_pkg;

    // Sizing of the identifier buffer and the line counter.
    localparam int KEYWORD_MAX_LEN = 13;
    localparam int LINE_BITS       = 16;
    localparam int LEN_W           = $clog2(KEYWORD_MAX_LEN + 1);
    localparam int IDX_W           = $clog2(KEYWORD_MAX_LEN);

    // Keyword table geometry: words are stored left aligned, padded with blanks.
    localparam int KW_COUNT    = 26;
    localparam int KW_WORD_LEN = 13;

    // Result queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Token codes.
    localparam logic [5:0] T_LPAREN     = 6'd0;
    localparam logic [5:0] T_RPAREN     = 6'd1;
    localparam logic [5:0] T_LBRACE     = 6'd2;
    localparam logic [5:0] T_RBRACE     = 6'd3;
    localparam logic [5:0] T_LSQUARE    = 6'd4;
    localparam logic [5:0] T_RSQUARE    = 6'd5;
    localparam logic [5:0] T_DOT        = 6'd6;
    localparam logic [5:0] T_COMMA      = 6'd7;
    localparam logic [5:0] T_COLON      = 6'd8;
    localparam logic [5:0] T_SEMI       = 6'd9;
    localparam logic [5:0] T_EQUAL      = 6'd10;
    localparam logic [5:0] T_NEWLINE    = 6'd11;
    localparam logic [5:0] T_PLUSPLUS   = 6'd12;
    localparam logic [5:0] T_PLUS       = 6'd13;
    localparam logic [5:0] T_MINUSMINUS = 6'd14;
    localparam logic [5:0] T_MINUS      = 6'd15;
    localparam logic [5:0] T_STARSTAR   = 6'd16;
    localparam logic [5:0] T_STAR       = 6'd17;
    localparam logic [5:0] T_SLASHSLASH = 6'd18;
    localparam logic [5:0] T_SLASH      = 6'd19;
    localparam logic [5:0] T_ASSIGN     = 6'd20;
    localparam logic [5:0] T_LE         = 6'd21;
    localparam logic [5:0] T_LT         = 6'd22;
    localparam logic [5:0] T_GE         = 6'd23;
    localparam logic [5:0] T_GT         = 6'd24;
    localparam logic [5:0] T_NE         = 6'd25;
    localparam logic [5:0] T_NOT        = 6'd26;
    localparam logic [5:0] T_STRING     = 6'd27;
    localparam logic [5:0] T_INTEGER    = 6'd28;
    localparam logic [5:0] T_REAL       = 6'd29;
    localparam logic [5:0] T_IDENT      = 6'd30;
    localparam logic [5:0] T_EOF        = 6'd56;
    localparam logic [5:0] T_UNKNOWN    = 6'd57;

    // Lexing mode, one-hot.
    typedef enum logic [11:0] {
        MODE_IDLE   = 12'b0000_0000_0001,
        MODE_PLUS   = 12'b0000_0000_0010,
        MODE_MINUS  = 12'b0000_0000_0100,
        MODE_STAR   = 12'b0000_0000_1000,
        MODE_SLASH  = 12'b0000_0001_0000,
        MODE_LT     = 12'b0000_0010_0000,
        MODE_GT     = 12'b0000_0100_0000,
        MODE_BANG   = 12'b0000_1000_0000,
        MODE_STRING = 12'b0001_0000_0000,
        MODE_INT    = 12'b0010_0000_0000,
        MODE_REAL   = 12'b0100_0000_0000,
        MODE_IDENT  = 12'b1000_0000_0000
    } mode_t;

    // One result word as it sits in the output queue.
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [7:0]  lexeme;
        logic        byte_valid;
        logic        last;
    } result_t;

    // Keyword spellings, lengths and token codes, in table order.
    localparam logic [8*KW_WORD_LEN-1:0] KW_WORD [KW_COUNT] = '{
        "IF           ", "ELSE         ", "ELSEIF       ", "ENDIF        ",
        "THEN         ", "FOR          ", "STEP         ", "TO           ",
        "ENDFOR       ", "DO           ", "WHILE        ", "ENDWHILE     ",
        "RETURN       ", "CONTINUE     ", "BREAK        ", "AND          ",
        "OR           ", "NOT          ", "TRUE         ", "FALSE        ",
        "SUBROUTINE   ", "ENDSUBROUTINE", "CLASS        ", "ENDCLASS     ",
        "PRINT        ", "INPUT        "
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd6, 4'd5, 4'd4, 4'd3, 4'd4, 4'd2, 4'd6, 4'd2, 4'd5, 4'd8, 4'd6,
        4'd8, 4'd5, 4'd3, 4'd2, 4'd3, 4'd4, 4'd5, 4'd10, 4'd13, 4'd5, 4'd8, 4'd5, 4'd5
    };

    localparam logic [5:0] KW_KIND [KW_COUNT] = '{
        6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40,
        6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46, 6'd47, T_NOT, 6'd48, 6'd49,
        6'd50, 6'd51, 6'd52, 6'd53, 6'd54, 6'd55
    };

    // Character classes.
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

endpackage

`default_nettype wire

// ===== design/pl_kw_match.sv =====
// Keyword matcher: compares the buffered identifier against the keyword table.
// Depends on pl_pkg for the table and buffer sizing.
`default_nettype none

module pl_kw_match (
    input  wire logic [7:0]               ident_buf [pl_pkg::KEYWORD_MAX_LEN],
    input  wire logic [pl_pkg::LEN_W-1:0] ident_len,
    input  wire logic                     ident_too_long,
    output logic [5:0]                    kind
);

    logic [pl_pkg::KW_COUNT-1:0] hit;

    // One comparator per keyword; only the bytes inside the keyword length count.
    always_comb
    begin
        for (int i = 0; i < pl_pkg::KW_COUNT; i++)
        begin
            hit[i] = (ident_len == pl_pkg::LEN_W'(pl_pkg::KW_LEN[i]));
            for (int j = 0; j < pl_pkg::KW_WORD_LEN; j++)
            begin
                if (j < int'(pl_pkg::KW_LEN[i]))
                begin
                    if (ident_buf[j] !=
                        pl_pkg::KW_WORD[i][8*(pl_pkg::KW_WORD_LEN-1-j) +: 8])
                    begin
                        hit[i] = 1'b0;
                    end
                end
            end
        end
    end

    // First hit in table order wins; an overlong identifier is never a keyword.
    always_comb
    begin
        kind = pl_pkg::T_IDENT;
        if (!ident_too_long)
        begin
            for (int i = pl_pkg::KW_COUNT - 1; i >= 0; i--)
            begin
                if (hit[i])
                begin
                    kind = pl_pkg::KW_KIND[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/pseudocode_lexer.sv =====
// Pseudocode lexer top level: input register, single-pass lexing step,
// result queue. Depends on pl_pkg and pl_kw_match.
// Flow: an accepted word waits in the input register, is lexed once the queue has
// room for two results, and its results are then offered from the result queue.
// Throughput: one input word per cycle while each causes at most one result and
// the queue has room; the single result port holds up words that give two results.
// Reset: asynchronous, active low; clears mode, line count, queue and handshakes.
`default_nettype none

module pseudocode_lexer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_in,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [5:0]       token_kind,
    output logic [15:0]      line_number,
    output logic [7:0]       lexeme_byte,
    output logic             byte_valid,
    output logic             last
);

    localparam logic [pl_pkg::LINE_BITS-1:0] LINE_MAX = {pl_pkg::LINE_BITS{1'b1}};

    // Input register.
    logic       in_full_reg;
    logic [7:0] char_reg;
    logic       eoi_reg;

    // Lexer state.
    pl_pkg::mode_t                  mode_reg, mode_next;
    logic [pl_pkg::LINE_BITS-1:0]   line_reg, line_next;
    logic [7:0]                     ident_buf_reg [pl_pkg::KEYWORD_MAX_LEN];
    logic [pl_pkg::LEN_W-1:0]       ident_len_reg, ident_len_next;
    logic                           too_long_reg, too_long_next;
    logic                           store_en;
    logic [pl_pkg::IDX_W-1:0]       store_idx;

    // Result queue.
    pl_pkg::result_t                fifo_reg [pl_pkg::FIFO_DEPTH];
    logic [pl_pkg::PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [pl_pkg::CNT_W-1:0]       count_reg;

    logic            process;
    logic            pop;
    logic [1:0]      n_res;
    pl_pkg::result_t res0, res1;
    logic [5:0]      kw_kind;

    // Step signals.
    logic            close_emit;
    logic [5:0]      close_kind;
    logic            pair_hit;
    logic [5:0]      pair_kind;
    logic            id_emit, id_bv, id_nl, id_start;
    logic [5:0]      id_kind;
    pl_pkg::mode_t   id_mode;
    logic [15:0]     line_old16, line_new16;
    logic [pl_pkg::LINE_BITS+15:0] line_old_ext, line_new_ext;

    // The step runs whenever a word waits and the queue can take two results.
    assign process  = in_full_reg && (count_reg <= pl_pkg::CNT_W'(pl_pkg::FIFO_DEPTH - 2));
    assign in_ready = !in_full_reg || process;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_in;
            eoi_reg  <= end_of_input;
        end
    end

    pl_kw_match u_kw_match (
        .ident_buf      (ident_buf_reg),
        .ident_len      (ident_len_reg),
        .ident_too_long (too_long_reg),
        .kind           (kw_kind)
    );

    // Token that closes the current mode.
    always_comb
    begin
        close_emit = (mode_reg != pl_pkg::MODE_IDLE);
        unique case (mode_reg)
            pl_pkg::MODE_PLUS:   close_kind = pl_pkg::T_PLUS;
            pl_pkg::MODE_MINUS:  close_kind = pl_pkg::T_MINUS;
            pl_pkg::MODE_STAR:   close_kind = pl_pkg::T_STAR;
            pl_pkg::MODE_SLASH:  close_kind = pl_pkg::T_SLASH;
            pl_pkg::MODE_LT:     close_kind = pl_pkg::T_LT;
            pl_pkg::MODE_GT:     close_kind = pl_pkg::T_GT;
            pl_pkg::MODE_BANG:   close_kind = pl_pkg::T_NOT;
            pl_pkg::MODE_STRING: close_kind = pl_pkg::T_STRING;
            pl_pkg::MODE_INT:    close_kind = pl_pkg::T_INTEGER;
            pl_pkg::MODE_REAL:   close_kind = pl_pkg::T_REAL;
            pl_pkg::MODE_IDENT:  close_kind = kw_kind;
            default:             close_kind = pl_pkg::T_UNKNOWN;
        endcase
    end

    // Two-character operators formed with the pending one.
    always_comb
    begin
        pair_hit  = 1'b1;
        pair_kind = pl_pkg::T_UNKNOWN;
        if (mode_reg == pl_pkg::MODE_PLUS && char_reg == "+")
            pair_kind = pl_pkg::T_PLUSPLUS;
        else if (mode_reg == pl_pkg::MODE_MINUS && char_reg == "-")
            pair_kind = pl_pkg::T_MINUSMINUS;
        else if (mode_reg == pl_pkg::MODE_STAR && char_reg == "*")
            pair_kind = pl_pkg::T_STARSTAR;
        else if (mode_reg == pl_pkg::MODE_SLASH && char_reg == "/")
            pair_kind = pl_pkg::T_SLASHSLASH;
        else if (mode_reg == pl_pkg::MODE_LT && char_reg == "-")
            pair_kind = pl_pkg::T_ASSIGN;
        else if (mode_reg == pl_pkg::MODE_LT && char_reg == "=")
            pair_kind = pl_pkg::T_LE;
        else if (mode_reg == pl_pkg::MODE_GT && char_reg == "=")
            pair_kind = pl_pkg::T_GE;
        else if (mode_reg == pl_pkg::MODE_BANG && char_reg == "=")
            pair_kind = pl_pkg::T_NE;
        else
            pair_hit = 1'b0;
    end

    // How a byte is handled when no token is open.
    always_comb
    begin
        id_emit  = 1'b1;
        id_kind  = '0;
        id_bv    = 1'b0;
        id_nl    = 1'b0;
        id_start = 1'b0;
        id_mode  = pl_pkg::MODE_IDLE;
        case (char_reg)
            " ", "\t": id_emit = 1'b0;
            "(":  id_kind = pl_pkg::T_LPAREN;
            ")":  id_kind = pl_pkg::T_RPAREN;
            "{":  id_kind = pl_pkg::T_LBRACE;
            "}":  id_kind = pl_pkg::T_RBRACE;
            "[":  id_kind = pl_pkg::T_LSQUARE;
            "]":  id_kind = pl_pkg::T_RSQUARE;
            ".":  id_kind = pl_pkg::T_DOT;
            ",":  id_kind = pl_pkg::T_COMMA;
            ":":  id_kind = pl_pkg::T_COLON;
            ";":  id_kind = pl_pkg::T_SEMI;
            "=":  id_kind = pl_pkg::T_EQUAL;
            "\n":
            begin
                id_kind = pl_pkg::T_NEWLINE;
                id_nl   = 1'b1;
            end
            "+":
            begin
                id_emit = 1'b0;
                id_mode = pl_pkg::MODE_PLUS;
            end
            "-":
            begin
                id_emit = 1'b0;
                id_mode = pl_pkg::MODE_MINUS;
            end
            "*":
            begin
                id_emit = 1'b0;
                id_mode = pl_pkg::MODE_STAR;
            end
            "/":
            begin
                id_emit = 1'b0;
                id_mode = pl_pkg::MODE_SLASH;
            end
            "<":
            begin
                id_emit = 1'b0;
                id_mode = pl_pkg::MODE_LT;
            end
            ">":
            begin
                id_emit = 1'b0;
                id_mode = pl_pkg::MODE_GT;
            end
            "!":
            begin
                id_emit = 1'b0;
                id_mode = pl_pkg::MODE_BANG;
            end
            "\"":
            begin
                id_emit = 1'b0;
                id_mode = pl_pkg::MODE_STRING;
            end
            default:
            begin
                if (pl_pkg::is_digit(char_reg))
                begin
                    id_bv   = 1'b1;
                    id_mode = pl_pkg::MODE_INT;
                end
                else if (pl_pkg::is_alpha(char_reg))
                begin
                    id_bv    = 1'b1;
                    id_start = 1'b1;
                    id_mode  = pl_pkg::MODE_IDENT;
                end
                else
                begin
                    id_kind = pl_pkg::T_UNKNOWN;
                end
            end
        endcase
    end

    // Low 16 bits of the line count before and after this word.
    assign line_old_ext = {16'd0, line_reg};
    assign line_new_ext = {16'd0, line_next};
    assign line_old16   = line_old_ext[15:0];
    assign line_new16   = line_new_ext[15:0];

    // One lexing step: next state and up to two results.
    always_comb
    begin
        logic do_close;
        logic do_idle;
        logic alnum;
        pl_pkg::result_t single;
        pl_pkg::result_t idle_res;

        do_close = 1'b0;
        do_idle  = 1'b0;
        alnum    = pl_pkg::is_digit(char_reg) || pl_pkg::is_alpha(char_reg);

        mode_next      = mode_reg;
        line_next      = line_reg;
        ident_len_next = ident_len_reg;
        too_long_next  = too_long_reg;
        store_en       = 1'b0;
        store_idx      = ident_len_reg[pl_pkg::IDX_W-1:0];
        n_res          = 2'd0;

        single.kind       = '0;
        single.line       = line_old16;
        single.lexeme     = char_reg;
        single.byte_valid = 1'b1;
        single.last       = 1'b0;
        res0 = single;
        res1 = single;
        idle_res = single;

        if (eoi_reg)
        begin
            // Close any open token, then the end-of-file token.
            mode_next         = pl_pkg::MODE_IDLE;
            single.kind       = pl_pkg::T_EOF;
            single.lexeme     = '0;
            single.byte_valid = 1'b0;
            if (close_emit)
            begin
                res0.kind       = close_kind;
                res0.lexeme     = '0;
                res0.byte_valid = 1'b0;
                res1  = single;
                n_res = 2'd2;
            end
            else
            begin
                res0  = single;
                n_res = 2'd1;
            end
        end
        else
        begin
            unique case (mode_reg)
                pl_pkg::MODE_IDLE:
                begin
                    do_idle = 1'b1;
                end
                pl_pkg::MODE_PLUS, pl_pkg::MODE_MINUS, pl_pkg::MODE_STAR,
                pl_pkg::MODE_SLASH, pl_pkg::MODE_LT, pl_pkg::MODE_GT, pl_pkg::MODE_BANG:
                begin
                    if (pair_hit)
                    begin
                        res0.kind       = pair_kind;
                        res0.lexeme     = '0;
                        res0.byte_valid = 1'b0;
                        n_res     = 2'd1;
                        mode_next = pl_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                pl_pkg::MODE_STRING:
                begin
                    if (char_reg == "\"")
                    begin
                        res0.kind       = pl_pkg::T_STRING;
                        res0.lexeme     = '0;
                        res0.byte_valid = 1'b0;
                        mode_next = pl_pkg::MODE_IDLE;
                    end
                    n_res = 2'd1;
                end
                pl_pkg::MODE_INT:
                begin
                    if (pl_pkg::is_digit(char_reg))
                    begin
                        n_res = 2'd1;
                    end
                    else if (char_reg == ".")
                    begin
                        n_res     = 2'd1;
                        mode_next = pl_pkg::MODE_REAL;
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                pl_pkg::MODE_REAL:
                begin
                    if (pl_pkg::is_digit(char_reg))
                    begin
                        n_res = 2'd1;
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                pl_pkg::MODE_IDENT:
                begin
                    if (alnum)
                    begin
                        n_res = 2'd1;
                        if (ident_len_reg < pl_pkg::LEN_W'(pl_pkg::KEYWORD_MAX_LEN))
                        begin
                            store_en       = 1'b1;
                            ident_len_next = pl_pkg::LEN_W'(ident_len_reg + 1'b1);
                        end
                        else
                        begin
                            too_long_next = 1'b1;
                        end
                    end
                    else
                    begin
                        do_close = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // Closing token of the open mode comes first.
            if (do_close)
            begin
                res0.kind       = close_kind;
                res0.lexeme     = '0;
                res0.byte_valid = 1'b0;
                n_res = 2'd1;
            end

            // Then the byte is taken as if no token were open.
            if (do_idle)
            begin
                mode_next = id_mode;
                if (id_nl && (line_reg != LINE_MAX))
                begin
                    line_next = line_reg + 1'b1;
                end
                if (id_start)
                begin
                    store_en       = 1'b1;
                    store_idx      = '0;
                    ident_len_next = pl_pkg::LEN_W'(1);
                    too_long_next  = 1'b0;
                end
                idle_res.kind       = id_bv ? 6'd0 : id_kind;
                idle_res.line       = line_new16;
                idle_res.lexeme     = id_bv ? char_reg : 8'd0;
                idle_res.byte_valid = id_bv;
                idle_res.last       = 1'b0;
                if (id_emit)
                begin
                    if (n_res == 2'd0)
                        res0 = idle_res;
                    else
                        res1 = idle_res;
                    n_res = n_res + 2'd1;
                end
            end
        end

        // Mark the final result of this word.
        if (n_res == 2'd2)
            res1.last = 1'b1;
        else
            res0.last = 1'b1;
    end

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= pl_pkg::MODE_IDLE;
            line_reg      <= '0;
            ident_len_reg <= '0;
            too_long_reg  <= 1'b0;
        end
        else if (process)
        begin
            mode_reg      <= mode_next;
            line_reg      <= line_next;
            ident_len_reg <= ident_len_next;
            too_long_reg  <= too_long_next;
        end
    end

    // Identifier buffer, written at most one byte per word.
    always_ff @(posedge clk)
    begin
        if (process && store_en)
        begin
            ident_buf_reg[store_idx] <= char_reg;
        end
    end

    // Result queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (process)
            begin
                wr_ptr_reg <= pl_pkg::PTR_W'(wr_ptr_reg + n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= pl_pkg::PTR_W'(rd_ptr_reg + 1'b1);
            end
            count_reg <= pl_pkg::CNT_W'(count_reg + (process ? n_res : 2'd0)
                                        - {{(pl_pkg::CNT_W-1){1'b0}}, pop});
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (process && (n_res != 2'd0))
        begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (process && (n_res == 2'd2))
        begin
            fifo_reg[pl_pkg::PTR_W'(wr_ptr_reg + 1'b1)] <= res1;
        end
    end

    assign token_kind  = fifo_reg[rd_ptr_reg].kind;
    assign line_number = fifo_reg[rd_ptr_reg].line;
    assign lexeme_byte = fifo_reg[rd_ptr_reg].lexeme;
    assign byte_valid  = fifo_reg[rd_ptr_reg].byte_valid;
    assign last        = fifo_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire
